// ----- design/bpc_pkg.sv -----
// ----------------------------------------------------------------------------
// bpc_pkg
// Shared types and constants of the barometric pressure compensation block.
// ----------------------------------------------------------------------------
package bpc_pkg;

    // One sample word: raw temperature and raw pressure conversions.
    typedef struct packed {
        logic [23:0] raw_temperature;
        logic [23:0] raw_pressure;
    } sample_t;

    // One result word.
    typedef struct packed {
        logic signed [14:0] celsius_hundredths;
        logic signed [15:0] fahrenheit_hundredths;
        logic [16:0]        pressure_pascal;
        logic [11:0]        mercury_hundredths;
    } result_t;

    // Factory calibration words.
    typedef struct packed {
        logic [15:0] sens_coeff;
        logic [15:0] offset_coeff;
        logic [15:0] sens_tempco;
        logic [15:0] offset_tempco;
        logic [15:0] ref_temp_raw;
        logic [15:0] temp_slope;
    } cal_t;

    // Register map, word index into the APB window.
    localparam int ADDR_W = 5;
    localparam logic [2:0] REG_SENS_COEFF    = 3'd0;
    localparam logic [2:0] REG_OFFSET_COEFF  = 3'd1;
    localparam logic [2:0] REG_SENS_TEMPCO   = 3'd2;
    localparam logic [2:0] REG_OFFSET_TEMPCO = 3'd3;
    localparam logic [2:0] REG_REF_TEMP_RAW  = 3'd4;
    localparam logic [2:0] REG_TEMP_SLOPE    = 3'd5;

    // Pipeline depth, input register through output register.
    localparam int NUM_STAGES = 12;

    // Sensor range and unit conversion constants.
    localparam int TEMP_BASE = 2000;
    localparam int TEMP_MIN  = -4000;
    localparam int TEMP_MAX  = 8500;
    localparam int PRES_MIN  = 1000;
    localparam int PRES_MAX  = 120000;
    localparam int FAHR_BASE = 32000;

    // ceil(2^21 / 10): exact divide by ten for magnitudes below 2^18.
    localparam logic [17:0] FAHR_RECIP = 18'd209716;
    // ceil(2^32 * 295 / 10000): exact p*295/10000 for p up to 120000.
    localparam logic [26:0] MERC_RECIP = 27'd126701536;

endpackage

// ----- design/bpc_pipe.sv -----
// ----------------------------------------------------------------------------
// bpc_pipe
// Twelve-stage compensation datapath; each stage loads when its enable is high.
// ----------------------------------------------------------------------------
module bpc_pipe
(
    input  logic                           clk,
    input  logic [bpc_pkg::NUM_STAGES-1:0] en,
    input  bpc_pkg::cal_t                  cal,
    input  bpc_pkg::sample_t               sample,
    output bpc_pkg::result_t               result
);
    import bpc_pkg::*;

    // Stage 0: temperature difference
    logic signed [24:0] s0_dt_reg, s0_dt_next;
    logic [23:0]        s0_d1_reg;

    // Stage 1: first products
    logic signed [41:0] s1_tr_prod_reg, s1_tr_prod_next;
    logic signed [49:0] dd_full;
    logic [47:0]        s1_dd_prod_reg;
    logic signed [41:0] s1_off_prod_reg, s1_off_prod_next;
    logic signed [41:0] s1_sens_prod_reg, s1_sens_prod_next;
    logic               s1_neg_reg;
    logic [23:0]        s1_d1_reg;

    // Stage 2: truncating shifts
    logic signed [41:0] tr_bias, off_bias, sens_bias;
    logic signed [17:0] s2_tr_reg;
    logic [16:0]        s2_dd_reg;
    logic signed [34:0] s2_offd_reg;
    logic signed [33:0] s2_sensd_reg;
    logic               s2_neg_reg;
    logic [23:0]        s2_d1_reg;

    // Stage 3: square of tr, first-order sums
    logic signed [35:0] sq_full;
    logic [33:0]        s3_sq_reg;
    logic signed [19:0] s3_temp_reg, s3_temp_next;
    logic signed [37:0] s3_off_base_reg, s3_off_base_next;
    logic signed [37:0] s3_sens_base_reg, s3_sens_base_next;
    logic               s3_neg_reg;
    logic [23:0]        s3_d1_reg;

    // Stage 4: second-order corrections, temperature clamp
    logic [39:0]        sq61;
    logic signed [37:0] s4_off_reg, s4_off_next;
    logic signed [37:0] s4_sens_reg, s4_sens_next;
    logic signed [14:0] s4_tc_reg, s4_tc_next;
    logic [23:0]        s4_d1_reg;

    // Stage 5: split pressure product, Fahrenheit numerator
    logic [42:0]        s5_pp_lo_reg;
    logic signed [43:0] s5_pp_hi_reg, s5_pp_hi_next;
    logic signed [37:0] s5_off_reg;
    logic signed [14:0] s5_tc_reg;
    logic signed [18:0] s5_fv_reg, s5_fv_next;

    // Stage 6: recombine product, scale Fahrenheit magnitude
    logic signed [62:0] s6_prod_reg, s6_prod_next;
    logic signed [37:0] s6_off_reg;
    logic signed [14:0] s6_tc_reg;
    logic [18:0]        fv_neg;
    logic [17:0]        fabs;
    logic [35:0]        s6_fmul_reg;
    logic               s6_fneg_reg;

    // Stage 7: product / 2^21, Fahrenheit sign
    logic signed [62:0] prod_bias;
    logic signed [41:0] s7_q_reg;
    logic signed [37:0] s7_off_reg;
    logic signed [14:0] s7_tc_reg;
    logic [14:0]        fq;
    logic signed [15:0] s7_fahr_reg, s7_fahr_next;

    // Stage 8: subtract offset
    logic signed [41:0] s8_diff_reg, s8_diff_next;
    logic signed [14:0] s8_tc_reg;
    logic signed [15:0] s8_fahr_reg;

    // Stage 9: pressure / 2^15
    logic signed [41:0] diff_bias;
    logic signed [26:0] s9_p_reg;
    logic signed [14:0] s9_tc_reg;
    logic signed [15:0] s9_fahr_reg;

    // Stage 10: pressure clamp
    logic [16:0]        s10_pc_reg, s10_pc_next;
    logic signed [14:0] s10_tc_reg;
    logic signed [15:0] s10_fahr_reg;

    // Stage 11: mercury conversion, output register
    logic [43:0]        merc_prod;
    result_t            out_reg, out_next;

    // ---------------- stage 0 ----------------
    assign s0_dt_next = $signed({1'b0, sample.raw_temperature})
                      - $signed({1'b0, cal.ref_temp_raw, 8'd0});

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            s0_dt_reg <= s0_dt_next;
            s0_d1_reg <= sample.raw_pressure;
        end
    end

    // ---------------- stage 1 ----------------
    assign s1_tr_prod_next   = 42'(s0_dt_reg) * 42'($signed({1'b0, cal.temp_slope}));
    assign dd_full           = 50'(s0_dt_reg) * 50'(s0_dt_reg);
    assign s1_off_prod_next  = 42'(s0_dt_reg) * 42'($signed({1'b0, cal.offset_tempco}));
    assign s1_sens_prod_next = 42'(s0_dt_reg) * 42'($signed({1'b0, cal.sens_tempco}));

    always_ff @(posedge clk)
    begin
        if (en[1])
        begin
            s1_tr_prod_reg   <= s1_tr_prod_next;
            s1_dd_prod_reg   <= dd_full[47:0];
            s1_off_prod_reg  <= s1_off_prod_next;
            s1_sens_prod_reg <= s1_sens_prod_next;
            s1_neg_reg       <= s0_dt_reg[24];
            s1_d1_reg        <= s0_d1_reg;
        end
    end

    // ---------------- stage 2 ----------------
    // Round negative quotients toward zero: add divisor minus one, then shift.
    assign tr_bias   = s1_tr_prod_reg
                     + (s1_tr_prod_reg[41] ? $signed({19'd0, {23{1'b1}}}) : 42'sd0);
    assign off_bias  = s1_off_prod_reg
                     + (s1_off_prod_reg[41] ? $signed({36'd0, 6'h3F}) : 42'sd0);
    assign sens_bias = s1_sens_prod_reg
                     + (s1_sens_prod_reg[41] ? $signed({35'd0, 7'h7F}) : 42'sd0);

    always_ff @(posedge clk)
    begin
        if (en[2])
        begin
            s2_tr_reg    <= tr_bias[40:23];
            s2_dd_reg    <= s1_dd_prod_reg[47:31];
            s2_offd_reg  <= off_bias[40:6];
            s2_sensd_reg <= sens_bias[40:7];
            s2_neg_reg   <= s1_neg_reg;
            s2_d1_reg    <= s1_d1_reg;
        end
    end

    // ---------------- stage 3 ----------------
    assign sq_full = 36'(s2_tr_reg) * 36'(s2_tr_reg);

    always_comb
    begin
        s3_temp_next = 20'(TEMP_BASE) + {{2{s2_tr_reg[17]}}, s2_tr_reg}
                     - (s2_neg_reg ? $signed({3'd0, s2_dd_reg}) : 20'sd0);
        s3_off_base_next  = $signed({5'd0, cal.offset_coeff, 17'd0})
                          + {{3{s2_offd_reg[34]}}, s2_offd_reg};
        s3_sens_base_next = $signed({6'd0, cal.sens_coeff, 16'd0})
                          + {{4{s2_sensd_reg[33]}}, s2_sensd_reg};
    end

    always_ff @(posedge clk)
    begin
        if (en[3])
        begin
            s3_sq_reg        <= sq_full[33:0];
            s3_temp_reg      <= s3_temp_next;
            s3_off_base_reg  <= s3_off_base_next;
            s3_sens_base_reg <= s3_sens_base_next;
            s3_neg_reg       <= s2_neg_reg;
            s3_d1_reg        <= s2_d1_reg;
        end
    end

    // ---------------- stage 4 ----------------
    // 61 * tr^2 as shifts and adds
    assign sq61 = {s3_sq_reg, 6'd0} - {4'd0, s3_sq_reg, 2'd0} + {6'd0, s3_sq_reg};

    always_comb
    begin
        s4_off_next  = s3_off_base_reg
                     - (s3_neg_reg ? $signed({2'd0, sq61[39:4]}) : 38'sd0);
        s4_sens_next = s3_sens_base_reg
                     - (s3_neg_reg ? $signed({3'd0, s3_sq_reg, 1'b0}) : 38'sd0);
        if (s3_temp_reg < 20'(TEMP_MIN))
            s4_tc_next = TEMP_MIN[14:0];
        else if (s3_temp_reg > 20'(TEMP_MAX))
            s4_tc_next = TEMP_MAX[14:0];
        else
            s4_tc_next = s3_temp_reg[14:0];
    end

    always_ff @(posedge clk)
    begin
        if (en[4])
        begin
            s4_off_reg  <= s4_off_next;
            s4_sens_reg <= s4_sens_next;
            s4_tc_reg   <= s4_tc_next;
            s4_d1_reg   <= s3_d1_reg;
        end
    end

    // ---------------- stage 5 ----------------
    // raw_pressure * sens as two 19-bit halves of sens
    assign s5_pp_hi_next = 44'($signed({1'b0, s4_d1_reg})) * 44'($signed(s4_sens_reg[37:19]));
    // c*18 + 32000
    assign s5_fv_next    = $signed({s4_tc_reg, 4'd0})
                         + $signed({{3{s4_tc_reg[14]}}, s4_tc_reg, 1'b0})
                         + 19'(FAHR_BASE);

    always_ff @(posedge clk)
    begin
        if (en[5])
        begin
            s5_pp_lo_reg <= 43'(s4_d1_reg) * 43'(s4_sens_reg[18:0]);
            s5_pp_hi_reg <= s5_pp_hi_next;
            s5_off_reg   <= s4_off_reg;
            s5_tc_reg    <= s4_tc_reg;
            s5_fv_reg    <= s5_fv_next;
        end
    end

    // ---------------- stage 6 ----------------
    assign s6_prod_next = $signed({s5_pp_hi_reg, 19'd0}) + $signed({20'd0, s5_pp_lo_reg});
    assign fv_neg       = 19'(-s5_fv_reg);
    assign fabs         = s5_fv_reg[18] ? fv_neg[17:0] : s5_fv_reg[17:0];

    always_ff @(posedge clk)
    begin
        if (en[6])
        begin
            s6_prod_reg <= s6_prod_next;
            s6_off_reg  <= s5_off_reg;
            s6_tc_reg   <= s5_tc_reg;
            s6_fmul_reg <= 36'(fabs) * 36'(FAHR_RECIP);
            s6_fneg_reg <= s5_fv_reg[18];
        end
    end

    // ---------------- stage 7 ----------------
    assign prod_bias = s6_prod_reg
                     + (s6_prod_reg[62] ? $signed({42'd0, 21'h1FFFFF}) : 63'sd0);
    assign fq        = s6_fmul_reg[35:21];
    assign s7_fahr_next = s6_fneg_reg ? -$signed({1'b0, fq}) : $signed({1'b0, fq});

    always_ff @(posedge clk)
    begin
        if (en[7])
        begin
            s7_q_reg    <= prod_bias[62:21];
            s7_off_reg  <= s6_off_reg;
            s7_tc_reg   <= s6_tc_reg;
            s7_fahr_reg <= s7_fahr_next;
        end
    end

    // ---------------- stage 8 ----------------
    assign s8_diff_next = s7_q_reg - {{4{s7_off_reg[37]}}, s7_off_reg};

    always_ff @(posedge clk)
    begin
        if (en[8])
        begin
            s8_diff_reg <= s8_diff_next;
            s8_tc_reg   <= s7_tc_reg;
            s8_fahr_reg <= s7_fahr_reg;
        end
    end

    // ---------------- stage 9 ----------------
    assign diff_bias = s8_diff_reg
                     + (s8_diff_reg[41] ? $signed({27'd0, 15'h7FFF}) : 42'sd0);

    always_ff @(posedge clk)
    begin
        if (en[9])
        begin
            s9_p_reg    <= diff_bias[41:15];
            s9_tc_reg   <= s8_tc_reg;
            s9_fahr_reg <= s8_fahr_reg;
        end
    end

    // ---------------- stage 10 ----------------
    always_comb
    begin
        if (s9_p_reg < 27'(PRES_MIN))
            s10_pc_next = PRES_MIN[16:0];
        else if (s9_p_reg > 27'(PRES_MAX))
            s10_pc_next = PRES_MAX[16:0];
        else
            s10_pc_next = s9_p_reg[16:0];
    end

    always_ff @(posedge clk)
    begin
        if (en[10])
        begin
            s10_pc_reg   <= s10_pc_next;
            s10_tc_reg   <= s9_tc_reg;
            s10_fahr_reg <= s9_fahr_reg;
        end
    end

    // ---------------- stage 11 ----------------
    assign merc_prod = 44'(s10_pc_reg) * 44'(MERC_RECIP);

    always_comb
    begin
        out_next.celsius_hundredths    = s10_tc_reg;
        out_next.fahrenheit_hundredths = s10_fahr_reg;
        out_next.pressure_pascal       = s10_pc_reg;
        out_next.mercury_hundredths    = merc_prod[43:32];
    end

    always_ff @(posedge clk)
    begin
        if (en[11])
            out_reg <= out_next;
    end

    assign result = out_reg;

endmodule

// ----- design/barometric_pressure_compensation.sv -----
// ----------------------------------------------------------------------------
// barometric_pressure_compensation: second-order pressure sensor compensation
// Throughput: one word per cycle while sample_stall is low; the wide multiplies
// and adds are spread across the pipeline stages.
// Reset: rst_n clears the calibration words and all stage valid bits at once.
// ----------------------------------------------------------------------------
module barometric_pressure_compensation
(
    input  logic                          clk,
    input  logic                          rst_n,

    // APB configuration port
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [bpc_pkg::ADDR_W-1:0]    paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready,

    // sample channel
    input  logic                          sample_valid,
    output logic                          sample_stall,
    input  bpc_pkg::sample_t              sample,

    // result channel
    output logic                          result_valid,
    input  logic                          result_stall,
    output bpc_pkg::result_t              result
);
    import bpc_pkg::*;

    cal_t                  cal_reg;
    logic [2:0]            reg_idx;
    logic                  cfg_write;

    // One valid bit per stage, traveling with the data.
    logic [NUM_STAGES-1:0] vld_reg, vld_next;
    // A stage may load when it or some stage downstream is empty, or the output word is taken.
    logic [NUM_STAGES-1:0] stage_free;

    // ------------------------------------------------------------------------
    // Configuration registers. Write on the access phase; pready is tied high
    // so every transfer completes without wait states. Addresses past the last
    // register write nothing and read as zero.
    // ------------------------------------------------------------------------
    assign pready    = 1'b1;
    assign reg_idx   = paddr[ADDR_W-1:2];
    assign cfg_write = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cal_reg <= '0;
        end
        else if (cfg_write)
        begin
            case (reg_idx)
                REG_SENS_COEFF:    cal_reg.sens_coeff    <= pwdata[15:0];
                REG_OFFSET_COEFF:  cal_reg.offset_coeff  <= pwdata[15:0];
                REG_SENS_TEMPCO:   cal_reg.sens_tempco   <= pwdata[15:0];
                REG_OFFSET_TEMPCO: cal_reg.offset_tempco <= pwdata[15:0];
                REG_REF_TEMP_RAW:  cal_reg.ref_temp_raw  <= pwdata[15:0];
                REG_TEMP_SLOPE:    cal_reg.temp_slope    <= pwdata[15:0];
                default:           cal_reg <= cal_reg;
            endcase
        end
    end

    always_comb
    begin
        case (reg_idx)
            REG_SENS_COEFF:    prdata = {16'd0, cal_reg.sens_coeff};
            REG_OFFSET_COEFF:  prdata = {16'd0, cal_reg.offset_coeff};
            REG_SENS_TEMPCO:   prdata = {16'd0, cal_reg.sens_tempco};
            REG_OFFSET_TEMPCO: prdata = {16'd0, cal_reg.offset_tempco};
            REG_REF_TEMP_RAW:  prdata = {16'd0, cal_reg.ref_temp_raw};
            REG_TEMP_SLOPE:    prdata = {16'd0, cal_reg.temp_slope};
            default:           prdata = 32'd0;
        endcase
    end

    // ------------------------------------------------------------------------
    // Flow control. Stage k is free when any stage from k to the output is
    // empty, or the output word is being taken. Bubbles collapse, so the
    // input keeps accepting while a finished word waits at the output as
    // long as some stage ahead is still empty.
    // ------------------------------------------------------------------------
    genvar k;
    generate
        for (k = 0; k < NUM_STAGES; k++)
        begin : g_free
            assign stage_free[k] = ~(&vld_reg[NUM_STAGES-1:k]) | ~result_stall;
        end
    endgenerate

    // Advance each valid bit into a free stage; hold it otherwise.
    always_comb
    begin
        vld_next[0] = stage_free[0] ? sample_valid : vld_reg[0];
        for (int i = 1; i < NUM_STAGES; i++)
            vld_next[i] = stage_free[i] ? vld_reg[i-1] : vld_reg[i];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else
            vld_reg <= vld_next;
    end

    assign sample_stall = ~stage_free[0];
    assign result_valid = vld_reg[NUM_STAGES-1];

    // ------------------------------------------------------------------------
    // Datapath: dt, products, truncating shifts, second-order terms, split
    // pressure multiply, offset subtract, clamps and unit conversions.
    // ------------------------------------------------------------------------
    bpc_pipe u_pipe
    (
        .clk    (clk),
        .en     (stage_free),
        .cal    (cal_reg),
        .sample (sample),
        .result (result)
    );

endmodule

// ----- design/bpc_checker.sv -----
// ----------------------------------------------------------------------------
// bpc_checker
// Port-level checks of the compensation block, bound to the top level.
// ----------------------------------------------------------------------------
module bpc_checker
(
    input logic             clk,
    input logic             rst_n,
    input logic             sample_stall,
    input logic             result_valid,
    input logic             result_stall,
    input bpc_pkg::result_t result
);
    import bpc_pkg::*;

    // A stalled result word stays offered.
    a_valid_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=> result_valid)
        else $error("result_valid dropped while stalled");

    // A stalled result word does not change.
    a_word_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=> $stable(result))
        else $error("result word changed while stalled");

    // With nothing waiting at the output the pipeline always accepts.
    a_no_stall_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !result_valid |-> !sample_stall)
        else $error("sample stalled with an empty output");

    // Temperature leaves saturated to the sensor range.
    a_temp_range: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> (result.celsius_hundredths >= -15'sd4000) &&
                         (result.celsius_hundredths <= 15'sd8500))
        else $error("temperature out of range");

    // Pressure leaves saturated to the sensor range.
    a_pres_range: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> (result.pressure_pascal >= 17'd1000) &&
                         (result.pressure_pascal <= 17'd120000))
        else $error("pressure out of range");

endmodule

bind barometric_pressure_compensation bpc_checker u_bpc_checker
(
    .clk          (clk),
    .rst_n        (rst_n),
    .sample_stall (sample_stall),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
);
